// ----- design/alst_pkg.sv -----
// ----------------------------------------------------------------------------
// alst_pkg: shared types and constants of the array list engine
// Opcodes, status codes, cell commands, sequencer states and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package alst_pkg;

    // Default number of entries
    localparam int DEF_CAPACITY = 64;

    // Field widths
    localparam int OPCODE_W   = 3;
    localparam int POS_W      = 6;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int FOUND_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_REPLACE = 3'd3,
        OP_SORT    = 3'd4,
        OP_SEARCH  = 3'd5,
        OP_CLEAR   = 3'd6
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SORT_EVEN,
        CELL_SORT_ODD
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                  cmd;
        logic signed [VALUE_W-1:0]  data;   // write value and search key
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SORT,
        S_SEARCH,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- design/alst_cell.sv -----
// ----------------------------------------------------------------------------
// alst_cell: one entry of the list chain
// Holds one value, shifts with its neighbors on insert and remove, takes part
// in odd-even transposition sorting, compares against the search key and
// forwards a read word toward cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module alst_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  wire logic                                   clk,
    input  wire alst_pkg::cell_ctrl_t                   ctrl,
    input  wire logic [CNT_W-1:0]                       pos,
    input  wire logic [CNT_W-1:0]                       count,
    input  wire logic signed [alst_pkg::VALUE_W-1:0]    lo_entry,
    input  wire logic signed [alst_pkg::VALUE_W-1:0]    hi_entry,
    input  wire logic signed [alst_pkg::VALUE_W-1:0]    rd_in,
    output logic signed [alst_pkg::VALUE_W-1:0]         entry,
    output logic signed [alst_pkg::VALUE_W-1:0]         rd_out,
    output logic                                        lt,
    output logic                                        eq
);

    localparam logic [CNT_W:0] MY_IDX   = (CNT_W+1)'(INDEX);
    localparam logic [CNT_W:0] NEXT_IDX = (CNT_W+1)'(INDEX + 1);
    localparam logic           PARITY   = 1'(INDEX % 2);

    logic signed [alst_pkg::VALUE_W-1:0] entry_reg, entry_next;
    logic signed [alst_pkg::VALUE_W-1:0] rd_reg;
    logic                                lt_reg, eq_reg;
    logic [CNT_W:0]                      pos_x, cnt_x;
    logic                                at_pos, above, lower_ok, upper_ok, odd_phase;

    assign pos_x    = {1'b0, pos};
    assign cnt_x    = {1'b0, count};
    assign at_pos   = (MY_IDX == pos_x);
    assign above    = (MY_IDX > pos_x);
    assign lower_ok = (NEXT_IDX < cnt_x);
    assign upper_ok = (INDEX > 0) && (MY_IDX < cnt_x);

    // Pick the next entry value
    always_comb
    begin
        entry_next = entry_reg;
        odd_phase  = (ctrl.cmd == alst_pkg::CELL_SORT_ODD);
        case (ctrl.cmd) inside
            alst_pkg::CELL_WRITE:
            begin
                if (at_pos)
                    entry_next = ctrl.data;
            end
            alst_pkg::CELL_INSERT:
            begin
                if (above)
                    entry_next = lo_entry;
                else if (at_pos)
                    entry_next = ctrl.data;
            end
            alst_pkg::CELL_REMOVE:
            begin
                if (at_pos || above)
                    entry_next = hi_entry;
            end
            alst_pkg::CELL_SORT_EVEN, alst_pkg::CELL_SORT_ODD:
            begin
                // Lower cell of a pair keeps the minimum, upper cell the maximum
                if (PARITY == odd_phase)
                begin
                    if (lower_ok && (entry_reg > hi_entry))
                        entry_next = hi_entry;
                end
                else
                begin
                    if (upper_ok && (lo_entry > entry_reg))
                        entry_next = lo_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Store entry, key flags and read word
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lt_reg    <= (ctrl.data < entry_reg);
        eq_reg    <= (ctrl.data == entry_reg);
        rd_reg    <= at_pos ? entry_reg : rd_in;
    end

    assign entry  = entry_reg;
    assign rd_out = rd_reg;
    assign lt     = lt_reg;
    assign eq     = eq_reg;

endmodule

`default_nettype wire

// ----- design/array_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// array_list_engine_core: fixed-capacity ordered list of signed 32-bit values
// Append, insert, remove, replace, sort, binary search and clear over a chain
// of entry cells driven by one sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  s_      | in  | s_tvalid / s_tready | opcode, position, value
//  m_      | out | m_tvalid / m_tready | status, removed_value, found_index,
//          |     |                     | entry_count
//
//  Append, insert, replace, clear: executed in S_EXEC, then S_FINISH.
//  Remove: the read word walks the chain to cell zero before the gap closes.
//  Sort: CAPACITY odd-even transposition passes.
//  Search: one binary-search probe a cycle until a hit or an empty range.
//  Reset clears count and control; entries are undefined until written.
//  A new word is taken while a result still waits on a stalled m_ side;
//  the sequencer then holds in its finish state until the output frees.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine_core #(
    parameter int CAPACITY = alst_pkg::DEF_CAPACITY
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // opcode[2:0], position[8:3], value[40:9], zero fill[47:41]
    input  wire logic [alst_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // status[2:0], removed_value[34:3], found_index[40:35], entry_count[47:41]
    output logic [alst_pkg::OUT_DATA_W-1:0]         m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int VW    = alst_pkg::VALUE_W;
    localparam int PW    = alst_pkg::POS_W;

    // Sequencer and result registers
    alst_pkg::state_t           state_reg, state_next;
    alst_pkg::opcode_t          op_reg;
    logic [PW-1:0]              pos_reg;
    logic signed [VW-1:0]       val_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           step_reg, step_next;
    logic [CNT_W-1:0]           lo_reg, lo_next, hi_reg, hi_next;
    alst_pkg::status_t          status_reg, status_next;
    logic signed [VW-1:0]       removed_reg, removed_next;
    logic [IDX_W-1:0]           found_reg, found_next;
    logic                       out_valid_reg;
    logic [alst_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                       out_load;

    // Chain signals
    alst_pkg::cell_ctrl_t       cell_ctrl;
    logic [CNT_W-1:0]           cell_pos;
    logic signed [VW-1:0]       ent [CAPACITY];
    logic signed [VW-1:0]       rd [CAPACITY];
    logic signed [VW-1:0]       lo_src [CAPACITY];
    logic signed [VW-1:0]       hi_src [CAPACITY];
    logic signed [VW-1:0]       rd_src [CAPACITY];
    logic [CAPACITY-1:0]        lt_vec, eq_vec;

    // Position and count checks at a width that holds both
    logic [CNT_W+PW-1:0]        pos_w, cnt_w;
    logic [CNT_W-1:0]           pos_c;
    logic                       full, empty;
    logic [CNT_W:0]             mid_sum;
    logic [CNT_W-1:0]           mid_w;
    logic [IDX_W-1:0]           mid_idx;
    logic [CNT_W+alst_pkg::COUNT_W-1:0] count_out_w;
    logic [IDX_W+alst_pkg::FOUND_W-1:0] found_out_w;

    assign pos_w   = {{CNT_W{1'b0}}, pos_reg};
    assign cnt_w   = {{PW{1'b0}}, count_reg};
    assign pos_c   = pos_w[CNT_W-1:0];
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W+1)'(1);
    assign mid_w   = mid_sum[CNT_W:1];
    assign mid_idx = mid_w[IDX_W-1:0];

    assign s_tready = (state_reg == alst_pkg::S_IDLE);

    // Next state, cell command and result
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        status_next   = status_reg;
        removed_next  = removed_reg;
        found_next    = found_reg;
        out_load      = 1'b0;
        cell_ctrl.cmd  = alst_pkg::CELL_HOLD;
        cell_ctrl.data = val_reg;
        cell_pos      = pos_c;
        unique case (state_reg)
            alst_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = alst_pkg::S_EXEC;
            end
            alst_pkg::S_EXEC:
            begin
                status_next  = alst_pkg::ST_OK;
                removed_next = '0;
                found_next   = '0;
                state_next   = alst_pkg::S_FINISH;
                case (op_reg)
                    alst_pkg::OP_APPEND:
                    begin
                        if (full)
                            status_next = alst_pkg::ST_FULL;
                        else
                        begin
                            cell_ctrl.cmd = alst_pkg::CELL_WRITE;
                            cell_pos      = count_reg;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    alst_pkg::OP_INSERT:
                    begin
                        if (pos_w > cnt_w)
                            status_next = alst_pkg::ST_BADPOS;
                        else if (full)
                            status_next = alst_pkg::ST_FULL;
                        else
                        begin
                            cell_ctrl.cmd = alst_pkg::CELL_INSERT;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    alst_pkg::OP_REMOVE:
                    begin
                        if (empty)
                            status_next = alst_pkg::ST_EMPTY;
                        else if (pos_w >= cnt_w)
                            status_next = alst_pkg::ST_BADPOS;
                        else
                        begin
                            step_next  = '0;
                            state_next = alst_pkg::S_READ;
                        end
                    end
                    alst_pkg::OP_REPLACE:
                    begin
                        if (empty)
                            status_next = alst_pkg::ST_EMPTY;
                        else if (pos_w >= cnt_w)
                            status_next = alst_pkg::ST_BADPOS;
                        else
                            cell_ctrl.cmd = alst_pkg::CELL_WRITE;
                    end
                    alst_pkg::OP_SORT:
                    begin
                        step_next  = '0;
                        state_next = alst_pkg::S_SORT;
                    end
                    alst_pkg::OP_SEARCH:
                    begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = alst_pkg::S_SEARCH;
                    end
                    alst_pkg::OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        status_next = alst_pkg::ST_OK;
                    end
                endcase
            end
            alst_pkg::S_READ:
            begin
                // Wait for the read word to reach cell zero, then close the gap
                if (step_reg == IDX_W'(CAPACITY - 1))
                begin
                    cell_ctrl.cmd = alst_pkg::CELL_REMOVE;
                    removed_next  = rd[0];
                    count_next    = count_reg - CNT_W'(1);
                    state_next    = alst_pkg::S_FINISH;
                end
                else
                    step_next = step_reg + IDX_W'(1);
            end
            alst_pkg::S_SORT:
            begin
                cell_ctrl.cmd = step_reg[0] ? alst_pkg::CELL_SORT_ODD
                                            : alst_pkg::CELL_SORT_EVEN;
                if (step_reg == IDX_W'(CAPACITY - 1))
                    state_next = alst_pkg::S_FINISH;
                else
                    step_next = step_reg + IDX_W'(1);
            end
            alst_pkg::S_SEARCH:
            begin
                // One probe a cycle over the half-open range lo..hi
                if (lo_reg < hi_reg)
                begin
                    if (eq_vec[mid_idx])
                    begin
                        found_next = mid_idx;
                        state_next = alst_pkg::S_FINISH;
                    end
                    else if (lt_vec[mid_idx])
                        hi_next = mid_w;
                    else
                        lo_next = mid_w + CNT_W'(1);
                end
                else
                begin
                    status_next = alst_pkg::ST_NOTFOUND;
                    state_next  = alst_pkg::S_FINISH;
                end
            end
            alst_pkg::S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = alst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = alst_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alst_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign count_out_w = {{alst_pkg::COUNT_W{1'b0}}, count_reg};
    assign found_out_w = {{alst_pkg::FOUND_W{1'b0}}, found_reg};

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= alst_pkg::opcode_t'(s_tdata[2:0]);
            pos_reg <= s_tdata[8:3];
            val_reg <= s_tdata[40:9];
        end
        step_reg    <= step_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        if (out_load)
            out_data_reg <= {count_out_w[alst_pkg::COUNT_W-1:0],
                             found_out_w[alst_pkg::FOUND_W-1:0],
                             removed_reg, status_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Chain of entry cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign lo_src[gi] = ent[gi];
            end
            else
            begin : g_mid_lo
                assign lo_src[gi] = ent[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign hi_src[gi] = ent[gi];
                assign rd_src[gi] = '0;
            end
            else
            begin : g_mid_hi
                assign hi_src[gi] = ent[gi+1];
                assign rd_src[gi] = rd[gi+1];
            end

            alst_cell #(
                .CNT_W (CNT_W),
                .INDEX (gi)
            ) u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .pos      (cell_pos),
                .count    (count_reg),
                .lo_entry (lo_src[gi]),
                .hi_entry (hi_src[gi]),
                .rd_in    (rd_src[gi]),
                .entry    (ent[gi]),
                .rd_out   (rd[gi]),
                .lt       (lt_vec[gi]),
                .eq       (eq_vec[gi])
            );
        end
    endgenerate

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alst_pkg::S_SEARCH) |-> (hi_reg <= count_reg))
        else $error("search range beyond entry count");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == alst_pkg::S_EXEC))
        else $error("accepted word not executed");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == alst_pkg::S_FINISH))
        else $error("result loaded outside finish state");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_array_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// tb_array_list_engine_core: self-checking bench of the array list engine
// Drives operation words on the s_ stream and checks every result word on
// the m_ stream against the list model or a typed answer. A directed table
// comes first, then random build, sort, search and edit sequences mixed
// with noise, under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_array_list_engine_core;

    import alst_pkg::*;

    localparam int LIST_CAP       = DEF_CAPACITY;
    localparam int RAND_PER_PHASE = 400;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 4 * LIST_CAP;
    localparam int CYCLE_LIMIT    = 2_000_000;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    // One result word, fields listed in m_tdata order from bit zero upward
    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  removed;
        logic [FOUND_W-1:0]         found;
        logic [COUNT_W-1:0]         count;
    } list_rsp_t;

    // One row of the directed table
    typedef struct {
        opcode_t                    op;
        logic [POS_W-1:0]           pos;
        logic signed [VALUE_W-1:0]  val;
        bit                         typed;
        list_rsp_t                  rsp;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // opcode[2:0], position[8:3], value[40:9], zero fill[47:41]
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // status[2:0], removed_value[34:3], found_index[40:35], entry_count[47:41]
    logic [OUT_DATA_W-1:0]  m_tdata;

    // Model of the list contents
    logic signed [VALUE_W-1:0] list_mem [LIST_CAP];
    int                        list_len = 0;

    list_rsp_t  pending_rsp_q [$];
    dir_row_t   dir_rows [$];
    int         errors = 0;
    int         words_sent = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;

    array_list_engine_core #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one operation to the list model and return its result word
    function automatic list_rsp_t apply_list_op(opcode_t op, logic [POS_W-1:0] pos,
                                                logic signed [VALUE_W-1:0] val);
        list_rsp_t                  r;
        int                         i;
        int                         j;
        int                         lo;
        int                         hi;
        int                         mid;
        logic signed [VALUE_W-1:0]  key;
        r.status  = ST_OK;
        r.removed = '0;
        r.found   = '0;
        case (op)
            OP_APPEND:
            begin
                if (list_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            OP_INSERT:
            begin
                // position check ranks ahead of the full check
                if (int'(pos) > list_len)
                    r.status = ST_BADPOS;
                else if (list_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > int'(pos); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            OP_REMOVE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (int'(pos) >= list_len)
                    r.status = ST_BADPOS;
                else
                begin
                    r.removed = list_mem[pos];
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            OP_REPLACE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (int'(pos) >= list_len)
                    r.status = ST_BADPOS;
                else
                    list_mem[pos] = val;
            end
            OP_SORT:
            begin
                // signed ascending insertion sort
                for (i = 1; i < list_len; i++)
                begin
                    key = list_mem[i];
                    j = i;
                    while (j > 0 && list_mem[j-1] > key)
                    begin
                        list_mem[j] = list_mem[j-1];
                        j--;
                    end
                    list_mem[j] = key;
                end
            end
            OP_SEARCH:
            begin
                // probe exactly as the block does, sorted or not
                r.status = ST_NOTFOUND;
                lo = 0;
                hi = list_len - 1;
                while (lo <= hi && r.status != ST_OK)
                begin
                    mid = (lo + hi) / 2;
                    if (val == list_mem[mid])
                    begin
                        r.status = ST_OK;
                        r.found  = mid[FOUND_W-1:0];
                    end
                    else if (val < list_mem[mid])
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
            end
            OP_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    // Mix of extremes, a narrow band that repeats often, and full range
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(5))
            0:
            begin
                case ($urandom_range(3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return $signed(32'($urandom_range(40))) - 32'sd20;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic void add_row(opcode_t op, logic [POS_W-1:0] pos,
                                    logic signed [VALUE_W-1:0] val, bit typed,
                                    status_t st, logic [COUNT_W-1:0] cnt);
        dir_row_t row;
        row.op          = op;
        row.pos         = pos;
        row.val         = val;
        row.typed       = typed;
        row.rsp.status  = st;
        row.rsp.removed = '0;
        row.rsp.found   = '0;
        row.rsp.count   = cnt;
        dir_rows.push_back(row);
    endfunction

    // Offer one word, wait for the handshake, then record what must come back
    task automatic issue(opcode_t op, logic [POS_W-1:0] pos,
                         logic signed [VALUE_W-1:0] val,
                         bit typed = 1'b0, list_rsp_t typed_rsp = '0);
        list_rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, val, pos, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_list_op(op, pos, val);
        pending_rsp_q.push_back(typed ? typed_rsp : predicted);
        words_sent++;
    endtask

    // Receiver: random stalls, plus one long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        list_rsp_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (m_tdata[2:0] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[34:3] !== want.removed)
                begin
                    $error("removed_value: expected %h, got %h", want.removed, m_tdata[34:3]);
                    errors++;
                end
                if (m_tdata[40:35] !== want.found)
                begin
                    $error("found_index: expected %0d, got %0d", want.found, m_tdata[40:35]);
                    errors++;
                end
                if (m_tdata[47:41] !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, m_tdata[47:41]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_array_list_engine_core failed");
        $finish;
    end

    initial
    begin
        int ph;
        int phase_end;
        int target;

        // Directed rows: typed where the answer is obvious, else modeled
        add_row(OP_REMOVE,  6'd0,  32'sd0,  1'b1, ST_EMPTY,    7'd0);
        add_row(OP_REPLACE, 6'd63, VAL_MAX, 1'b1, ST_EMPTY,    7'd0);
        add_row(OP_SEARCH,  6'd0,  32'sd0,  1'b1, ST_NOTFOUND, 7'd0);
        add_row(OP_SORT,    6'd0,  32'sd0,  1'b1, ST_OK,       7'd0);
        add_row(OP_INSERT,  6'd1,  32'sd7,  1'b1, ST_BADPOS,   7'd0);
        add_row(OP_INSERT,  6'd0,  VAL_MAX, 1'b1, ST_OK,       7'd1);
        add_row(OP_APPEND,  6'd63, VAL_MIN, 1'b1, ST_OK,       7'd2);
        add_row(OP_INSERT,  6'd63, 32'sd5,  1'b1, ST_BADPOS,   7'd2);
        add_row(OP_INSERT,  6'd2,  32'sd0,  1'b1, ST_OK,       7'd3);
        add_row(OP_REPLACE, 6'd3,  32'sd9,  1'b1, ST_BADPOS,   7'd3);
        add_row(OP_REPLACE, 6'd1,  -32'sd1, 1'b0, ST_OK,       7'd0);
        add_row(OP_INSERT,  6'd1,  VAL_MIN, 1'b0, ST_OK,       7'd0);
        add_row(OP_SORT,    6'd0,  32'sd0,  1'b0, ST_OK,       7'd0);
        add_row(OP_SEARCH,  6'd0,  VAL_MAX, 1'b0, ST_OK,       7'd0);
        add_row(OP_SEARCH,  6'd0,  VAL_MIN, 1'b0, ST_OK,       7'd0);
        add_row(OP_SEARCH,  6'd0,  32'sd12345, 1'b0, ST_OK,    7'd0);
        add_row(OP_REMOVE,  6'd3,  32'sd0,  1'b0, ST_OK,       7'd0);
        add_row(OP_REMOVE,  6'd63, 32'sd0,  1'b1, ST_BADPOS,   7'd3);
        add_row(OP_APPEND,  6'd0,  32'sd42, 1'b0, ST_OK,       7'd0);
        add_row(OP_SEARCH,  6'd0,  -32'sd1, 1'b0, ST_OK,       7'd0);
        add_row(OP_CLEAR,   6'd0,  32'sd0,  1'b1, ST_OK,       7'd0);
        add_row(OP_APPEND,  6'd0,  32'sd0,  1'b1, ST_OK,       7'd1);

        // Hold reset, then release on a rising edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            issue(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].val,
                  dir_rows[k].typed, dir_rows[k].rsp);

        // Random phases, each with its own idling mix
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    // long receiver hold-off while words keep coming
                    hold_req = 1'b1;
                end
                1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            phase_end = words_sent + RAND_PER_PHASE;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(9) < 6)
                begin
                    // Build a list, maybe sort it, search it, edit it
                    if ($urandom_range(3) != 0)
                        issue(OP_CLEAR, 6'($urandom_range(63)), pick_value());
                    target = ($urandom_range(3) == 0) ? LIST_CAP : $urandom_range(1, 20);
                    while (list_len < target)
                    begin
                        if ($urandom_range(1) != 0)
                            issue(OP_APPEND, 6'($urandom_range(63)), pick_value());
                        else
                            issue(OP_INSERT, 6'($urandom_range(list_len)), pick_value());
                    end
                    // push against a full list
                    if (list_len == LIST_CAP)
                        repeat (2)
                            issue(($urandom_range(1) != 0) ? OP_APPEND : OP_INSERT,
                                  6'($urandom_range(63)), pick_value());
                    if ($urandom_range(9) < 7)
                        issue(OP_SORT, 6'($urandom_range(63)), pick_value());
                    repeat ($urandom_range(3, 8))
                        issue(OP_SEARCH, 6'($urandom_range(63)),
                              (list_len > 0 && $urandom_range(4) < 3)
                                  ? list_mem[$urandom_range(list_len - 1)]
                                  : pick_value());
                    repeat ($urandom_range(1, 4))
                        issue(($urandom_range(1) != 0) ? OP_REMOVE : OP_REPLACE,
                              (list_len > 0 && $urandom_range(4) != 0)
                                  ? 6'($urandom_range(list_len - 1))
                                  : 6'($urandom_range(63)),
                              pick_value());
                end
                else
                begin
                    // Noise: any opcode including the unused one, any position
                    repeat (10)
                        issue(opcode_t'($urandom_range(7)), 6'($urandom_range(63)),
                              pick_value());
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_rsp_q.size() == 0)
            $display("tb_array_list_engine_core passed");
        else
            $display("tb_array_list_engine_core failed");
        $finish;
    end

endmodule

// ----- array_list_engine_core.f -----
design/alst_pkg.sv
design/alst_cell.sv
design/array_list_engine_core.sv
verif/tb_array_list_engine_core.sv
